FILE: design/wbps_pkg.sv
// shared types and constants for the wildcard byte pattern scanner
package wbps_pkg;

  localparam int REG_BYTES   = 16;   // pattern bytes held by the two pattern registers
  localparam int LEN_W       = 5;    // width of the pattern length register
  localparam int ADDR_W      = 64;   // match address width
  localparam int OUT_COUNT_W = 32;   // match count width on the result word
  localparam int PADDR_W     = 6;    // byte address of six 64-bit registers
  localparam int PDATA_W     = 64;

  // register indexes, paddr[5:3]
  localparam logic [2:0] REG_BASE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_PATTERN_LOW  = 3'd1;
  localparam logic [2:0] REG_PATTERN_HIGH = 3'd2;
  localparam logic [2:0] REG_CARE_MASK    = 3'd3;
  localparam logic [2:0] REG_PATTERN_LEN  = 3'd4;
  localparam logic [2:0] REG_REPORT_ALL   = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0]      base_address;
    logic [8*REG_BYTES-1:0] pattern;       // byte k in bits 8k+7..8k
    logic [REG_BYTES-1:0]   care_mask;
    logic [LEN_W-1:0]       pattern_length;
    logic                   report_all;
  } cfg_t;

endpackage

FILE: design/wbps_cfg.sv
// configuration register file with apb-style access
module wbps_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wbps_pkg::PADDR_W-1:0]  paddr,
  input  logic [wbps_pkg::PDATA_W-1:0]  pwdata,
  output logic [wbps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output wbps_pkg::cfg_t                cfg
);
  import wbps_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BASE_ADDRESS: cfg.base_address          <= pwdata;
        REG_PATTERN_LOW:  cfg.pattern[63:0]         <= pwdata;
        REG_PATTERN_HIGH: cfg.pattern[127:64]       <= pwdata;
        REG_CARE_MASK:    cfg.care_mask             <= pwdata[REG_BYTES-1:0];
        REG_PATTERN_LEN:  cfg.pattern_length        <= pwdata[LEN_W-1:0];
        REG_REPORT_ALL:   cfg.report_all            <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_ADDRESS: prdata = cfg.base_address;
      REG_PATTERN_LOW:  prdata = cfg.pattern[63:0];
      REG_PATTERN_HIGH: prdata = cfg.pattern[127:64];
      REG_CARE_MASK:    prdata = PDATA_W'(cfg.care_mask);
      REG_PATTERN_LEN:  prdata = PDATA_W'(cfg.pattern_length);
      REG_REPORT_ALL:   prdata = PDATA_W'(cfg.report_all);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: design/wbps_scan.sv
// byte window, masked compare, counters and result register
module wbps_scan #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wbps_pkg::cfg_t                      cfg,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wbps_pkg::ADDR_W-1:0]         match_address,
  output logic [wbps_pkg::OUT_COUNT_W-1:0]    match_count,
  output logic                                is_match,
  output logic                                done_res
);
  import wbps_pkg::*;

  localparam int LEN_CAP   = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
  localparam int WIN_DEPTH = (LEN_CAP > 1) ? LEN_CAP - 1 : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]      SEEN_MAX  = '1;

  logic [7:0]             window [WIN_DEPTH];
  logic [ADDR_W-1:0]      bytes_seen;
  logic [COUNT_WIDTH-1:0] matches_found;

  logic [7:0]             hist [LEN_CAP];
  logic [7:0]             hist_sel [LEN_CAP];
  logic [LEN_CAP-1:0]     mismatch;
  logic [LEN_W-1:0]       len;
  logic [ADDR_W-1:0]      seen_next;
  logic [COUNT_WIDTH-1:0] matches_next;
  logic [OUT_COUNT_W-1:0] count_out;
  logic                   armed;
  logic                   hit;
  logic                   accept;

  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  // hist[0] is the incoming byte, hist[k] the byte k words earlier
  always_comb begin
    hist[0] = s_tdata;
    for (int k = 1; k < LEN_CAP; k++) begin
      hist[k] = window[k-1];
    end
  end

  assign len = (cfg.pattern_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : cfg.pattern_length;
  assign seen_next = (bytes_seen == SEEN_MAX) ? bytes_seen : bytes_seen + ADDR_W'(1);

  // pattern byte j lines up with the window byte len-1-j words back
  always_comb begin
    for (int j = 0; j < LEN_CAP; j++) begin
      hist_sel[j] = '0;
      for (int k = 0; k < LEN_CAP; k++) begin
        if (LEN_W'(k) == len - LEN_W'(j) - LEN_W'(1)) begin
          hist_sel[j] = hist[k];
        end
      end
      mismatch[j] = (LEN_W'(j) < len) && cfg.care_mask[j] &&
                    (hist_sel[j] != cfg.pattern[8*j +: 8]);
    end
  end

  assign armed = (cfg.base_address != '0) && (len != '0) &&
                 (seen_next >= ADDR_W'(len)) &&
                 (cfg.report_all || (matches_found == '0));
  assign hit   = armed && ~(|mismatch);

  assign matches_next = (hit && (matches_found != COUNT_MAX)) ?
                        matches_found + COUNT_WIDTH'(1) : matches_found;

  generate
    if (COUNT_WIDTH > OUT_COUNT_W) begin : g_count_sat
      assign count_out = (|matches_next[COUNT_WIDTH-1:OUT_COUNT_W]) ?
                         '1 : matches_next[OUT_COUNT_W-1:0];
    end else begin : g_count_ext
      assign count_out = OUT_COUNT_W'(matches_next);
    end
  endgenerate

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      matches_found <= '0;
      for (int k = 0; k < WIN_DEPTH; k++) begin
        window[k] <= '0;
      end
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen    <= '0;
        matches_found <= '0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
          window[k] <= '0;
        end
      end else begin
        bytes_seen    <= seen_next;
        matches_found <= matches_next;
        window[0]     <= s_tdata;
        for (int k = 1; k < WIN_DEPTH; k++) begin
          window[k] <= window[k-1];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && (hit || s_tlast)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (hit || s_tlast)) begin
      match_address <= hit ? cfg.base_address + seen_next - ADDR_W'(len) : '0;
      is_match      <= hit;
      done_res      <= s_tlast;
      match_count   <= count_out;
    end
  end

endmodule

FILE: design/wildcard_byte_pattern_scanner_top.sv
// top level of the wildcard byte pattern scanner
// usage:
//   program base address, the two pattern words, care mask, pattern length
//   and report mode over the apb port while the scanner is idle
//   stream the region one byte per word on the slave side; tlast marks
//   the final byte of the region
//   the master side carries one result word per match and one for the
//   last byte; tuser is set on a match word, tlast on the last-byte word
//   (a match on the last byte gives a single word with both set)
//   a zero base address or zero pattern length disables matching
// timing:
//   one byte is taken every cycle while s_tready is high; its result is shown the cycle after,
//   held in a single output register; the window compare is one level of
//   parallel byte compares plus a 64-bit address add
//   when the receiver stalls, s_tready drops only while the output
//   register is full and not being taken
// reset:
//   clears the registers, the window, the byte count and the match count;
//   the last byte of a region clears the search state for the next one
module wildcard_byte_pattern_scanner_top #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wbps_pkg::PADDR_W-1:0]  paddr,
  input  logic [wbps_pkg::PDATA_W-1:0]  pwdata,
  output logic [wbps_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // byte stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // data_byte
  input  logic                          s_tlast,   // last_byte
  // result stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [95:0]                   m_tdata,   // match_address [63:0], match_count [95:64]
  output logic                          m_tuser,   // is_match
  output logic                          m_tlast    // done_res
);
  import wbps_pkg::*;

  cfg_t                   cfg;
  logic [ADDR_W-1:0]      match_address;
  logic [OUT_COUNT_W-1:0] match_count;

  wbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // window, compare and result register
  wbps_scan #(
    .PATTERN_MAX (PATTERN_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .match_address (match_address),
    .match_count   (match_count),
    .is_match      (m_tuser),
    .done_res      (m_tlast)
  );

  // pack the result word, address in the low bits
  assign m_tdata = {match_count, match_address};

endmodule

FILE: tb/tb_wildcard_byte_pattern_scanner_top.sv
// self-checking testbench for the wildcard byte pattern scanner top level
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner_top;
  import wbps_pkg::*;

  // cycles with no handshake of any kind before the run is declared hung
  localparam int STALL_LIMIT  = 3000;
  // receiver hold-off used to fill the block and stall its input
  localparam int HOLD_CYCLES  = 400;
  // result register is one stage deep; settle time after the last expected word
  localparam int DRAIN_CYCLES = 4;

  // one expected result word
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] count;
    logic        hit;
    logic        done;
  } scan_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;

  // apb side, idle from time zero
  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [5:0]   paddr   = '0;
  logic [63:0]  pwdata  = '0;
  logic [63:0]  prdata;
  logic         pready;

  // byte stream in
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;     // data_byte
  logic         s_tlast  = 1'b0;   // last_byte

  // result stream out
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;           // match_address [63:0], match_count [95:64]
  logic         m_tuser;           // is_match
  logic         m_tlast;           // done_res

  // shadow copy of the scanner registers
  logic [63:0]  cur_base    = '0;
  logic [127:0] cur_pattern = '0;  // byte k in bits 8k+7..8k
  logic [15:0]  cur_care    = '0;
  logic [4:0]   cur_len     = '0;
  logic         cur_all     = 1'b0;

  // shadow copy of the search state
  logic [7:0]   win_hist [15] = '{default: 8'h00};  // entry 0 is the newest byte
  logic [63:0]  region_bytes  = '0;
  logic [31:0]  region_hits   = '0;

  scan_result_t pending_results [$];

  int           err_cnt      = 0;
  int           tx_idle_pct  = 0;
  int           rx_stall_pct = 0;
  logic         rx_hold_req  = 1'b0;
  int           rx_hold_left = 0;
  int           quiet_cycles = 0;

  wildcard_byte_pattern_scanner_top uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: one accepted byte in, zero or one expected word out
  // ---------------------------------------------------------------------------
  function automatic void scan_byte(input logic [7:0] b, input logic lst);
    logic [7:0]   hist [16];
    int           n;
    logic         hit;
    logic [63:0]  addr;
    scan_result_t res;

    // hist[k] is the byte k steps back, hist[0] the one just taken
    hist[0] = b;
    for (int j = 1; j < 16; j++) hist[j] = win_hist[j-1];
    if (region_bytes != '1) region_bytes++;

    // lengths above sixteen clamp to the full window
    n    = (cur_len > 5'd16) ? 16 : int'(cur_len);
    hit  = 1'b0;
    addr = '0;
    if (cur_base != '0 && n != 0 && region_bytes >= 64'(n) &&
        (cur_all || region_hits == '0)) begin
      hit = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the window
      for (int j = 0; j < n; j++) begin
        if (cur_care[j] && hist[n-1-j] != cur_pattern[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        addr = cur_base + (region_bytes - 64'(n));
        if (region_hits != '1) region_hits++;
      end
    end
    for (int j = 0; j < 15; j++) win_hist[j] = hist[j];

    if (hit || lst) begin
      res.addr  = addr;
      res.count = region_hits;
      res.hit   = hit;
      res.done  = lst;
      pending_results.insert(pending_results.size(), res);
    end

    // last byte closes the region and clears the search
    if (lst) begin
      foreach (win_hist[i]) win_hist[i] = 8'h00;
      region_bytes = '0;
      region_hits  = '0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 60) $display("mismatch at %0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------
  // setup then access; bus is left selected so writes can go back to back
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE_ADDRESS: cur_base             = val;
      REG_PATTERN_LOW:  cur_pattern[63:0]    = val;
      REG_PATTERN_HIGH: cur_pattern[127:64]  = val;
      REG_CARE_MASK:    cur_care             = val[15:0];
      REG_PATTERN_LEN:  cur_len              = val[4:0];
      REG_REPORT_ALL:   cur_all              = val[0];
      default: ;
    endcase
  endtask

  task automatic program_scan(input logic [63:0] base, input logic [63:0] plo,
                              input logic [63:0] phi, input logic [15:0] care,
                              input logic [4:0] len, input logic all);
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_PATTERN_LOW, plo);
    write_reg(REG_PATTERN_HIGH, phi);
    write_reg(REG_CARE_MASK, 64'(care));
    write_reg(REG_PATTERN_LEN, 64'(len));
    write_reg(REG_REPORT_ALL, 64'(all));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // byte stream driver
  // ---------------------------------------------------------------------------
  // tvalid stays high between back-to-back words; it only drops for a gap
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    scan_byte(b, lst);
  endtask

  task automatic send_region(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // stop offering, let every expected word come out, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req <= 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest expected word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, addr %h", m_tdata[63:0]));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[63:0] !== want.addr)
          report_mismatch($sformatf("match_address %h, expected %h", m_tdata[63:0], want.addr));
        if (m_tdata[95:64] !== want.count)
          report_mismatch($sformatf("match_count %0d, expected %0d", m_tdata[95:64], want.count));
        if (m_tuser !== want.hit)
          report_mismatch($sformatf("is_match %b, expected %b", m_tuser, want.hit));
        if (m_tlast !== want.done)
          report_mismatch($sformatf("done_res %b, expected %b", m_tlast, want.done));
      end
    end
  end

  // hang detector: any handshake on any port restarts the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------
  // registers at reset: zero base, zero length, only the done word comes out
  task automatic test_idle_defaults();
    send_region('{8'h00, 8'hFF});
    wait_drained();
  endtask

  // every match reported, address wraps past the top, match on the last byte
  task automatic test_wrap_every_match();
    program_scan(64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_0055_AA55, '1, 16'hFFFF, 5'd3, 1'b1);
    send_region('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
    wait_drained();
  endtask

  // first-only mode, second occurrence stays silent
  task automatic test_first_only();
    program_scan(64'h1, 64'h0000_0000_0055_AA55, '0, 16'hFFFF, 5'd3, 1'b0);
    send_region('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
    wait_drained();
  endtask

  // region shorter than the pattern, zero length, zero base
  task automatic test_short_and_off();
    send_region('{8'h55, 8'hAA});
    wait_drained();
    program_scan(64'h4000, '0, '0, 16'h0000, 5'd0, 1'b1);
    send_region('{8'h55, 8'hAA});
    wait_drained();
    program_scan(64'h0, '0, '0, 16'h0000, 5'd2, 1'b1);
    send_region('{8'h00, 8'hFF});
    wait_drained();
  endtask

  // middle byte is a don't-care
  task automatic test_wildcards();
    program_scan(64'h8000_0000_0000_0000, 64'h0000_0000_0055_FF55, '1, 16'h0005, 5'd3, 1'b1);
    send_region('{8'h55, 8'h00, 8'h55, 8'hFF, 8'h55});
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // random traffic
  // ---------------------------------------------------------------------------
  task automatic randomize_scan();
    logic [63:0] base;
    logic [15:0] care;
    logic [4:0]  len;
    int          r;
    r = $urandom_range(99);
    if (r < 8)       base = '0;
    else if (r < 18) base = '1 - 64'($urandom_range(40));
    else             base = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 5)       len = 5'd0;
    else if (r < 60) len = 5'($urandom_range(4, 1));
    else if (r < 87) len = 5'($urandom_range(16, 5));
    else             len = 5'($urandom_range(31, 17));
    r = $urandom_range(99);
    if (r < 15)      care = 16'hFFFF;
    else if (r < 22) care = 16'h0000;
    else             care = 16'($urandom);
    program_scan(base, {$urandom, $urandom}, {$urandom, $urandom}, care, len,
                 1'($urandom_range(1)));
  endtask

  // mostly planted pattern copies with random wildcard bytes, some with one
  // bit flipped, the rest pattern-like bytes and plain noise
  task automatic random_region(input int rlen);
    logic [7:0] bytes [$];
    logic [7:0] b;
    int         n;
    int         r;
    int         flip;
    n = (cur_len > 5'd16) ? 16 : int'(cur_len);
    while (bytes.size() < rlen) begin
      r = $urandom_range(99);
      if (r < 35 && n > 0) begin
        flip = (r < 7) ? $urandom_range(n - 1) : n;
        for (int j = 0; j < n; j++) begin
          b = cur_care[j] ? cur_pattern[8*j +: 8] : 8'($urandom);
          if (j == flip) b = b ^ (8'h01 << $urandom_range(7));
          bytes.insert(bytes.size(), b);
        end
      end else if (r < 70) begin
        bytes.insert(bytes.size(), cur_pattern[8*$urandom_range(15) +: 8]);
      end else begin
        bytes.insert(bytes.size(), 8'($urandom_range(255)));
      end
    end
    while (bytes.size() > rlen) void'(bytes.pop_back());
    send_region(bytes);
  endtask

  task automatic test_random_traffic(input int items, input int tx_pct, input int rx_pct);
    int sent;
    int rlen;
    sent         = 0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (sent < items) begin
      randomize_scan();
      rlen = ($urandom_range(99) < 12) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      random_region(rlen);
      sent += rlen;
      wait_drained();
    end
  endtask

  // receiver holds off while the sender keeps pushing; every window matches
  // so the output register fills at once and the input has to stall
  task automatic test_backpressure_fill();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    program_scan(64'h10_0000, '0, '0, 16'h0000, 5'd2, 1'b1);
    rx_hold_req <= 1'b1;
    random_region(40);
    wait_drained();
  endtask

  // sender stops mid-region until all words are out, then finishes the region
  task automatic test_midregion_drain();
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    program_scan(64'h2000, 64'h0000_0000_0000_3C3C, '0, 16'h0003, 5'd2, 1'b1);
    for (int i = 0; i < 10; i++) send_byte(($urandom_range(1) != 0) ? 8'h3C : 8'h00, 1'b0);
    wait_drained();
    for (int i = 0; i < 10; i++) send_byte(($urandom_range(1) != 0) ? 8'h3C : 8'h00, i == 9);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_idle_defaults();
    test_wrap_every_match();
    test_first_only();
    test_short_and_off();
    test_wildcards();

    test_random_traffic(440, 0, 0);
    test_backpressure_fill();
    test_random_traffic(440, 73, 0);
    test_random_traffic(440, 0, 73);
    test_midregion_drain();
    test_random_traffic(440, 12, 12);

    // nothing left to send; let any stray word show up before the verdict
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
